FILE: rtl/orthonormal_color_transform_assert.svh
// assertion macros, sampled on clk and held off while rst_n is low
`ifndef ORTHONORMAL_COLOR_TRANSFORM_ASSERT_SVH
`define ORTHONORMAL_COLOR_TRANSFORM_ASSERT_SVH

// same-cycle implication
`define OCT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OCT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/oct_pkg.sv
package oct_pkg;

  localparam int COEF_W      = 17;
  localparam int FRAC_SHIFT  = 15;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 2;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [3:0]              coef_row_t;
  typedef coef_row_t [3:0]          coef_mat_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MODE = 1'b1;

  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_THREE = 2'd1;
  localparam logic [1:0] MODE_FOUR  = 2'd2;

  localparam logic DIR_FORWARD = 1'b0;
  localparam logic DIR_INVERSE = 1'b1;

  // Q2.15 coefficients, unity only for passthrough
  localparam coef_t C_ONE = 17'sd32768;
  localparam coef_t C_R3  = 17'sd18919;
  localparam coef_t C_R2  = 17'sd23170;
  localparam coef_t C_R6  = 17'sd13378;
  localparam coef_t C_T6  = 17'sd26755;
  localparam coef_t C_H   = 17'sd16384;

  function automatic coef_mat_t coef_matrix(input logic [1:0] mode, input logic dir);
    coef_mat_t m;
    m = '0;
    unique case (mode)
      MODE_PASS: begin
        m[0][0] = C_ONE;
        m[1][1] = C_ONE;
        m[2][2] = C_ONE;
      end
      MODE_THREE: begin
        if (dir == DIR_INVERSE) begin
          m[0][0] = C_R3; m[0][1] = C_R2;  m[0][2] = C_R6;
          m[1][0] = C_R3; m[1][1] = '0;    m[1][2] = -C_T6;
          m[2][0] = C_R3; m[2][1] = -C_R2; m[2][2] = C_R6;
        end else begin
          m[0][0] = C_R3; m[0][1] = C_R3;  m[0][2] = C_R3;
          m[1][0] = C_R2; m[1][1] = '0;    m[1][2] = -C_R2;
          m[2][0] = C_R6; m[2][1] = -C_T6; m[2][2] = C_R6;
        end
      end
      default: begin
        if (dir == DIR_INVERSE) begin
          m[0][0] = C_H; m[0][1] = '0;    m[0][2] = -C_H; m[0][3] = -C_R2;
          m[1][0] = C_H; m[1][1] = C_R2;  m[1][2] = C_H;  m[1][3] = '0;
          m[2][0] = C_H; m[2][1] = -C_R2; m[2][2] = C_H;  m[2][3] = '0;
          m[3][0] = C_H; m[3][1] = '0;    m[3][2] = -C_H; m[3][3] = C_R2;
        end else begin
          m[0][0] = C_H;   m[0][1] = C_H;  m[0][2] = C_H;   m[0][3] = C_H;
          m[1][0] = '0;    m[1][1] = C_R2; m[1][2] = -C_R2; m[1][3] = '0;
          m[2][0] = -C_H;  m[2][1] = C_H;  m[2][2] = C_H;   m[2][3] = -C_H;
          m[3][0] = -C_R2; m[3][1] = '0;   m[3][2] = '0;    m[3][3] = C_R2;
        end
      end
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/oct_in_if.sv
interface oct_in_if #(
  parameter int SAMPLE_WIDTH = 20
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_a;
  logic signed [SAMPLE_WIDTH-1:0] sample_b;
  logic signed [SAMPLE_WIDTH-1:0] sample_c;
  logic signed [SAMPLE_WIDTH-1:0] sample_d;

  modport source (output valid, sample_a, sample_b, sample_c, sample_d, input ready);
  modport sink   (input valid, sample_a, sample_b, sample_c, sample_d, output ready);
endinterface

FILE: rtl/oct_out_if.sv
interface oct_out_if #(
  parameter int SAMPLE_WIDTH = 20
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] result_a;
  logic signed [SAMPLE_WIDTH-1:0] result_b;
  logic signed [SAMPLE_WIDTH-1:0] result_c;
  logic signed [SAMPLE_WIDTH-1:0] result_d;
  logic                           saturated;

  modport source (output valid, result_a, result_b, result_c, result_d, saturated,
                  input ready);
  modport sink   (input valid, result_a, result_b, result_c, result_d, saturated,
                  output ready);
endinterface

FILE: rtl/oct_row.sv
module oct_row
  import oct_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 20
) (
  input  logic                           clk,
  input  pipe_en_t                       en,
  input  logic signed [SAMPLE_WIDTH-1:0] sample [4],
  input  coef_row_t                      coef,
  output logic signed [SAMPLE_WIDTH-1:0] result,
  output logic                           clip
);

  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int Q_W    = ACC_W - FRAC_SHIFT;

  logic signed [PROD_W-1:0]       prod_r [4];
  logic signed [PROD_W-1:0]       prod_nxt [4];
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [ACC_W-1:0]        acc_nxt;
  logic signed [ACC_W-1:0]        rnd;
  logic signed [Q_W-1:0]          q;
  logic signed [Q_W-1:0]          max_q;
  logic signed [Q_W-1:0]          min_q;
  logic signed [SAMPLE_WIDTH-1:0] result_r;
  logic signed [SAMPLE_WIDTH-1:0] result_nxt;
  logic                           clip_r;
  logic                           clip_nxt;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      prod_nxt[j] = PROD_W'(sample[j]) * PROD_W'($signed(coef[j]));
    end
  end

  assign acc_nxt = ACC_W'(prod_r[0]) + ACC_W'(prod_r[1]) + ACC_W'(prod_r[2])
                 + ACC_W'(prod_r[3]);

  // round half up, then clip to the sample range
  assign rnd   = acc_r + ACC_W'(1 << (FRAC_SHIFT - 1));
  assign q     = Q_W'(rnd >>> FRAC_SHIFT);
  assign max_q = {{(Q_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  assign min_q = {{(Q_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  always_comb begin
    priority if (q > max_q) begin
      result_nxt = max_q[SAMPLE_WIDTH-1:0];
      clip_nxt   = 1'b1;
    end else if (q < min_q) begin
      result_nxt = min_q[SAMPLE_WIDTH-1:0];
      clip_nxt   = 1'b1;
    end else begin
      result_nxt = q[SAMPLE_WIDTH-1:0];
      clip_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_r <= prod_nxt;
    end
    if (en.s3) begin
      acc_r <= acc_nxt;
    end
    if (en.s4) begin
      result_r <= result_nxt;
      clip_r   <= clip_nxt;
    end
  end

  assign result = result_r;
  assign clip   = clip_r;

endmodule

FILE: rtl/orthonormal_color_transform.sv
// Orthonormal per-pixel color transform: a 3x3 orthonormal matrix (or its transpose)
// for RGB with three channels, a 4x4 orthonormal matrix for four Bayer channels, or
// passthrough with three channels. One pixel is taken every clock unless the pipeline
// is full and the output is stalled. Each pixel passes the input register, 16 parallel
// multipliers, a four-way sum, then round and clip into the output register. A stage
// holds only while it is full and the stage after it is stalled, so bubbles close up.
// The user must write registers only while the block is empty; the block itself does
// not enforce it. After reset the mode is three channels, forward.
`include "orthonormal_color_transform_assert.svh"

module orthonormal_color_transform
  import oct_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  oct_in_if.sink                 in_ch,
  oct_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic                           dir_r;
  logic [1:0]                     mode_r;
  logic                           v1_r;
  logic                           v2_r;
  logic                           v3_r;
  logic                           v4_r;
  logic                           en1;
  pipe_en_t                       en;
  logic signed [SAMPLE_WIDTH-1:0] smp_r [4];
  coef_mat_t                      coef_r;
  logic signed [SAMPLE_WIDTH-1:0] res [4];
  logic [3:0]                     clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= DIR_FORWARD;
      mode_r <= MODE_THREE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIRECTION:    dir_r  <= cfg_wdata[0];
        REG_CHANNEL_MODE: mode_r <= cfg_wdata[1:0];
      endcase
    end
  end

  assign en.s4 = !v4_r || out_ch.ready;
  assign en.s3 = !v3_r || en.s4;
  assign en.s2 = !v2_r || en.s3;
  assign en1   = !v1_r || en.s2;

  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_ch.valid;
      end
      if (en.s2) begin
        v2_r <= v1_r;
      end
      if (en.s3) begin
        v3_r <= v2_r;
      end
      if (en.s4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      smp_r[0] <= in_ch.sample_a;
      smp_r[1] <= in_ch.sample_b;
      smp_r[2] <= in_ch.sample_c;
      smp_r[3] <= in_ch.sample_d;
      coef_r   <= coef_matrix(mode_r, dir_r);
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_row
    oct_row #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_row (
      .clk    (clk),
      .en     (en),
      .sample (smp_r),
      .coef   (coef_r[i]),
      .result (res[i]),
      .clip   (clip[i])
    );
  end

  assign out_ch.valid     = v4_r;
  assign out_ch.result_a  = res[0];
  assign out_ch.result_b  = res[1];
  assign out_ch.result_c  = res[2];
  assign out_ch.result_d  = res[3];
  assign out_ch.saturated = |clip;

  // input stalls only when the first stage holds an item
  `OCT_ASSERT_IMP(a_stall_needs_item, !in_ch.ready, v1_r, "input stalled with stage 1 empty")
  // an item in stage 3 behind a stalled output is kept
  `OCT_ASSERT_NXT(a_s3_kept, v3_r && v4_r && !out_ch.ready, v3_r, "stage 3 item lost on stall")
  // a new result only comes from stage 3
  `OCT_ASSERT_IMP(a_out_from_s3, $rose(v4_r), $past(v3_r), "result valid without source item")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import oct_pkg::*;

  localparam int SW = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int HOLD_AFTER = 150;
  localparam int PHASE_ITEMS = 50;
  localparam int TAIL_CYCLES = 12;

  // mode code 3 behaves as four channels
  localparam logic [1:0] MODE_FOUR_ALT = 2'd3;

  localparam longint K_R3 = 18919;
  localparam longint K_R2 = 23170;
  localparam longint K_R6 = 13378;
  localparam longint K_T6 = 26755;
  localparam longint K_H  = 16384;
  localparam longint SAT_HI = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint SAT_LO = -(64'sd1 <<< (SW - 1));

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = sample_t'(SAT_HI);
  localparam sample_t SAMPLE_MIN = sample_t'(SAT_LO);

  typedef struct packed {
    sample_t a;
    sample_t b;
    sample_t c;
    sample_t d;
  } pixel_t;

  typedef struct packed {
    sample_t a;
    sample_t b;
    sample_t c;
    sample_t d;
    logic    sat;
  } transform_t;

  class color_scoreboard;
    logic         dir_q;
    logic [1:0]   mode_q;
    transform_t   expected_q[$];
    int           mismatch_count;

    function new();
      dir_q = DIR_FORWARD;
      mode_q = MODE_THREE;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_DIRECTION) begin
        dir_q = data[0];
      end else if (idx == REG_CHANNEL_MODE) begin
        mode_q = data[1:0];
      end
    endfunction

    function longint coef(bit four, bit inv, int r, int c);
      longint m[4][4];
      if (four) begin
        m = '{'{K_H, K_H, K_H, K_H}, '{0, K_R2, -K_R2, 0},
              '{-K_H, K_H, K_H, -K_H}, '{-K_R2, 0, 0, K_R2}};
      end else begin
        m = '{'{K_R3, K_R3, K_R3, 0}, '{K_R2, 0, -K_R2, 0},
              '{K_R6, -K_T6, K_R6, 0}, '{0, 0, 0, 0}};
      end
      // inverse is the transpose in both modes
      return inv ? m[c][r] : m[r][c];
    endfunction

    function void note_pixel(pixel_t px);
      longint     s[4];
      longint     acc;
      longint     q;
      sample_t    r[4];
      logic       clip;
      int         n;
      transform_t t;
      s[0] = px.a;
      s[1] = px.b;
      s[2] = px.c;
      s[3] = px.d;
      r = '{default: '0};
      clip = 1'b0;
      if (mode_q == MODE_PASS) begin
        r[0] = px.a;
        r[1] = px.b;
        r[2] = px.c;
      end else begin
        n = (mode_q == MODE_THREE) ? 3 : 4;
        for (int i = 0; i < n; i++) begin
          acc = 0;
          for (int j = 0; j < n; j++) begin
            acc += coef(n == 4, dir_q == DIR_INVERSE, i, j) * s[j];
          end
          q = (acc + 16384) >>> 15;
          if (q > SAT_HI) begin
            q = SAT_HI;
            clip = 1'b1;
          end
          if (q < SAT_LO) begin
            q = SAT_LO;
            clip = 1'b1;
          end
          r[i] = sample_t'(q);
        end
      end
      t.a = r[0];
      t.b = r[1];
      t.c = r[2];
      t.d = r[3];
      t.sat = clip;
      expected_q.push_back(t);
    endfunction

    task report(string what, int got, int want);
      mismatch_count++;
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    task check_result(transform_t got);
      transform_t want;
      if (expected_q.size() == 0) begin
        report("unexpected transfer, result_a", got.a, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.a !== want.a) report("result_a", got.a, want.a);
        if (got.b !== want.b) report("result_b", got.b, want.b);
        if (got.c !== want.c) report("result_c", got.c, want.c);
        if (got.d !== want.d) report("result_d", got.d, want.d);
        if (got.sat !== want.sat) report("saturated", got.sat, want.sat);
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  oct_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
  oct_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

  orthonormal_color_transform #(.SAMPLE_WIDTH(SW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  color_scoreboard sb = new();
  int accepted_count = 0;
  int cycle_count = 0;
  bit hold_done = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    pixel_t px;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      px.a = in_ch.sample_a;
      px.b = in_ch.sample_b;
      px.c = in_ch.sample_c;
      px.d = in_ch.sample_d;
      sb.note_pixel(px);
      accepted_count++;
    end
  end

  always @(posedge clk) begin
    transform_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.a = out_ch.result_a;
      got.b = out_ch.result_b;
      got.c = out_ch.result_c;
      got.d = out_ch.result_d;
      got.sat = out_ch.saturated;
      sb.check_result(got);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // receiver stall pattern, with one long hold-off once traffic is flowing
  initial begin
    int seg_len;
    int style;
    int k;
    out_ch.ready <= 1'b0;
    forever begin
      if (!hold_done && accepted_count >= HOLD_AFTER) begin
        hold_done = 1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          out_ch.ready <= 1'b0;
        end
      end
      seg_len = $urandom_range(4, 40);
      style = $urandom_range(0, 3);
      for (k = 0; k < seg_len; k++) begin
        if (!hold_done && accepted_count >= HOLD_AFTER) break;
        @(posedge clk);
        case (style)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= k[1];
        endcase
      end
    end
  end

  function automatic sample_t pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: begin
        v = $urandom_range(0, 4095);
        return sample_t'(v - 2048);
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.a = pick_sample();
    px.b = pick_sample();
    px.c = pick_sample();
    px.d = pick_sample();
    return px;
  endfunction

  task automatic send_pixel(input pixel_t px);
    in_ch.valid <= 1'b1;
    in_ch.sample_a <= px.a;
    in_ch.sample_b <= px.b;
    in_ch.sample_c <= px.c;
    in_ch.sample_d <= px.d;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic [CFG_DATA_W-1:0] dir_word,
                              input logic [CFG_DATA_W-1:0] mode_word);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_DIRECTION;
    cfg_wdata <= dir_word;
    @(posedge clk);
    sb.write_reg(REG_DIRECTION, dir_word);
    cfg_index <= REG_CHANNEL_MODE;
    cfg_wdata <= mode_word;
    @(posedge clk);
    sb.write_reg(REG_CHANNEL_MODE, mode_word);
    cfg_we <= 1'b0;
  endtask

  task automatic send_directed();
    pixel_t px;
    px = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX};
    send_pixel(px);
    px = '{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN};
    send_pixel(px);
    idle_for($urandom_range(0, 3));
    px = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX};
    send_pixel(px);
    // rounding of small values near zero
    px = '{sample_t'(1), sample_t'(0), sample_t'(-1), sample_t'(0)};
    send_pixel(px);
  endtask

  task automatic send_random(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) send_pixel(random_pixel());
      left -= burst;
      idle_for($urandom_range(0, 6));
    end
  endtask

  initial begin
    logic [1:0] dir_word;
    logic [1:0] mode_word;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_DIRECTION;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.sample_a <= '0;
    in_ch.sample_b <= '0;
    in_ch.sample_c <= '0;
    in_ch.sample_d <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings first, then every mode code; the direction word's spare bit is set in three writes
    send_directed();
    apply_config({1'b1, DIR_INVERSE}, MODE_THREE);
    send_directed();
    apply_config({1'b0, DIR_FORWARD}, MODE_FOUR);
    send_directed();
    apply_config({1'b0, DIR_INVERSE}, MODE_FOUR);
    send_directed();
    apply_config({1'b1, DIR_INVERSE}, MODE_PASS);
    send_directed();
    apply_config({1'b1, DIR_FORWARD}, MODE_FOUR_ALT);
    send_directed();

    for (int p = 0; p < 10; p++) begin
      if (p < 8) begin
        mode_word = 2'(p / 2);
        dir_word = {1'($urandom_range(0, 1)), 1'(p % 2)};
      end else begin
        mode_word = 2'($urandom_range(0, 3));
        dir_word = 2'($urandom_range(0, 3));
      end
      apply_config(dir_word, mode_word);
      send_random(PHASE_ITEMS);
    end

    wait_drained();
    if (sb.mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: orthonormal_color_transform.f
+incdir+rtl
rtl/oct_pkg.sv
rtl/oct_in_if.sv
rtl/oct_out_if.sv
rtl/oct_row.sv
rtl/orthonormal_color_transform.sv
tb/tb.sv
